// File: sv/tcw_pkg.sv
package tcw_pkg;

    localparam int SEQ_W      = 32;
    localparam int WIN_W      = 7;
    localparam int DUP_W      = 4;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;

    localparam int MAX_WINDOW = 64;

    localparam logic [WIN_W-1:0] RST_THRESHOLD = WIN_W'(8);
    localparam logic [SEQ_W-1:0] RST_SEQUENCE  = SEQ_W'(1);
    localparam logic [DUP_W-1:0] RST_DUP_THR   = DUP_W'(3);
    localparam logic [WIN_W-1:0] RST_WINDOW    = WIN_W'(1);
    localparam logic [DUP_W-1:0] RST_DUP_CNT   = DUP_W'(1);
    localparam logic [DUP_W-1:0] DUP_CNT_MAX   = DUP_W'(15);

    // request opcodes
    localparam logic [OP_W-1:0] OP_SEND   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK    = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    // response kinds
    localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESHOLD  = 2'd2;

    typedef struct packed {
        logic gt;
        logic eq;
    } tcw_cmp_t;

endpackage

// File: sv/tcw_if.sv
interface tcw_req_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::OP_W-1:0]    op;
    logic [tcw_pkg::SEQ_W-1:0]   ack_number;

    modport source (output valid, output op, output ack_number, input ready);
    modport sink   (input valid, input op, input ack_number, output ready);
endinterface

interface tcw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::KIND_W-1:0]  kind;
    logic [tcw_pkg::SEQ_W-1:0]   segment_number;
    logic                        last;
    logic [tcw_pkg::WIN_W-1:0]   window;
    logic [tcw_pkg::WIN_W-1:0]   threshold;
    logic                        slow_start;
    logic                        triple_dup;

    modport source (output valid, output kind, output segment_number, output last,
                    output window, output threshold, output slow_start,
                    output triple_dup, input ready);
    modport sink   (input valid, input kind, input segment_number, input last,
                    input window, input threshold, input slow_start,
                    input triple_dup, output ready);
endinterface

interface tcw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tcw_pkg::CFG_IDX_W-1:0]   index;
    logic [tcw_pkg::SEQ_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/tcw_addcmp.sv
module tcw_addcmp (
    input  logic [tcw_pkg::SEQ_W-1:0] a,
    input  logic [tcw_pkg::SEQ_W-1:0] b,
    output logic [tcw_pkg::SEQ_W-1:0] sum,
    output tcw_pkg::tcw_cmp_t         cmp
);

    // shared 32-bit adder and unsigned comparator
    assign sum    = a + b;
    assign cmp.gt = (a > b);
    assign cmp.eq = (a == b);

endmodule

// File: sv/tcp_congestion_window_control_top.sv
// Ack and end-of-round requests: accepted in ST_IDLE, result registered from ST_ACK or
// ST_UPDATE once the output is free, next request taken after the return to ST_IDLE.
// Send rounds: segments follow acceptance one per cycle, window_size of them,
// through the shared 32-bit adder; the block takes no request until the last segment
// is registered. Output back-pressure stretches both.
// Reset (async, active low) restores all window state at once; no clear pass.
module tcp_congestion_window_control_top (
    input  logic           clk,
    input  logic           rst_n,
    tcw_req_if.sink        req,
    tcw_rsp_if.source      rsp,
    tcw_cfg_if.sink        cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEND,
        ST_ACK,
        ST_UPDATE
    } state_t;

    state_t                          state_reg, state_next;
    logic [tcw_pkg::SEQ_W-1:0]       acked_reg, acked_next;
    logic [tcw_pkg::SEQ_W-1:0]       ack_in_reg, ack_in_next;
    logic [tcw_pkg::WIN_W-1:0]       win_reg, win_next;
    logic [tcw_pkg::WIN_W-1:0]       lim_reg, lim_next;
    logic [tcw_pkg::DUP_W-1:0]       dup_reg, dup_next;
    logic [tcw_pkg::DUP_W-1:0]       dup_thr_reg, dup_thr_next;
    logic                            loss_reg, loss_next;
    logic [tcw_pkg::WIN_W-1:0]       cnt_reg, cnt_next;

    logic                            out_valid_reg, out_valid_next;
    logic [tcw_pkg::KIND_W-1:0]      out_kind_reg, out_kind_next;
    logic [tcw_pkg::SEQ_W-1:0]       out_seg_reg, out_seg_next;
    logic                            out_last_reg, out_last_next;
    logic [tcw_pkg::WIN_W-1:0]       out_win_reg, out_win_next;
    logic [tcw_pkg::WIN_W-1:0]       out_thr_reg, out_thr_next;
    logic                            out_ss_reg, out_ss_next;
    logic                            out_dup_reg, out_dup_next;

    logic [tcw_pkg::SEQ_W-1:0]       unit_a;
    logic [tcw_pkg::SEQ_W-1:0]       unit_b;
    logic [tcw_pkg::SEQ_W-1:0]       unit_sum;
    tcw_pkg::tcw_cmp_t               unit_cmp;

    logic                            out_free;
    logic                            seg_last;
    logic [tcw_pkg::DUP_W-1:0]       dup_inc;
    logic [tcw_pkg::WIN_W:0]         win_dbl;
    logic [tcw_pkg::WIN_W:0]         win_inc;

    function automatic logic [tcw_pkg::WIN_W-1:0] clamp_win(input logic [tcw_pkg::WIN_W:0] w);
        if (w > (tcw_pkg::WIN_W+1)'(tcw_pkg::MAX_WINDOW))
            return tcw_pkg::WIN_W'(tcw_pkg::MAX_WINDOW);
        else
            return w[tcw_pkg::WIN_W-1:0];
    endfunction

    tcw_addcmp u_addcmp (
        .a   (unit_a),
        .b   (unit_b),
        .sum (unit_sum),
        .cmp (unit_cmp)
    );

    // send rounds add the segment offset, acks compare against the acked number
    always_comb
    begin
        if (state_reg == ST_SEND)
        begin
            unit_a = acked_reg;
            unit_b = {{(tcw_pkg::SEQ_W-tcw_pkg::WIN_W){1'b0}}, cnt_reg};
        end
        else
        begin
            unit_a = ack_in_reg;
            unit_b = acked_reg;
        end
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign seg_last  = (cnt_reg == tcw_pkg::WIN_W'(win_reg - 1'b1));
    assign dup_inc   = (dup_reg < tcw_pkg::DUP_CNT_MAX) ? dup_reg + 1'b1 : dup_reg;
    assign win_dbl   = {win_reg, 1'b0};
    assign win_inc   = {1'b0, win_reg} + 1'b1;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = (state_reg == ST_IDLE);

    assign rsp.valid          = out_valid_reg;
    assign rsp.kind           = out_kind_reg;
    assign rsp.segment_number = out_seg_reg;
    assign rsp.last           = out_last_reg;
    assign rsp.window         = out_win_reg;
    assign rsp.threshold      = out_thr_reg;
    assign rsp.slow_start     = out_ss_reg;
    assign rsp.triple_dup     = out_dup_reg;

    always_comb
    begin
        state_next     = state_reg;
        acked_next     = acked_reg;
        ack_in_next    = ack_in_reg;
        win_next       = win_reg;
        lim_next       = lim_reg;
        dup_next       = dup_reg;
        dup_thr_next   = dup_thr_reg;
        loss_next      = loss_reg;
        cnt_next       = cnt_reg;

        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_seg_next   = out_seg_reg;
        out_last_next  = out_last_reg;
        out_win_next   = out_win_reg;
        out_thr_next   = out_thr_reg;
        out_ss_next    = out_ss_reg;
        out_dup_next   = out_dup_reg;

        // configuration lands only while idle
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                tcw_pkg::CFG_INIT_THRESHOLD: lim_next     = cfg.data[tcw_pkg::WIN_W-1:0];
                tcw_pkg::CFG_START_SEQUENCE: acked_next   = cfg.data;
                tcw_pkg::CFG_DUP_THRESHOLD:  dup_thr_next = cfg.data[tcw_pkg::DUP_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    ack_in_next = req.ack_number;
                    cnt_next    = '0;
                    unique case (req.op)
                        tcw_pkg::OP_SEND:   state_next = ST_SEND;
                        tcw_pkg::OP_ACK:    state_next = ST_ACK;
                        tcw_pkg::OP_UPDATE: state_next = ST_UPDATE;
                        default:            state_next = ST_IDLE;  // drop unknown op
                    endcase
                end
            end

            ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = tcw_pkg::KIND_SEGMENT;
                    out_seg_next   = unit_sum;
                    out_last_next  = seg_last;
                    out_win_next   = win_reg;
                    out_thr_next   = lim_reg;
                    out_ss_next    = (lim_reg > win_reg);
                    out_dup_next   = loss_reg;
                    cnt_next       = cnt_reg + 1'b1;
                    if (seg_last)
                        state_next = ST_IDLE;
                end
            end

            ST_ACK:
            begin
                if (out_free)
                begin
                    if (unit_cmp.gt)
                    begin
                        acked_next = ack_in_reg;
                        dup_next   = tcw_pkg::RST_DUP_CNT;
                    end
                    else if (unit_cmp.eq)
                    begin
                        dup_next = dup_inc;
                        if (dup_inc == dup_thr_reg)
                            loss_next = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    out_kind_next  = tcw_pkg::KIND_ACK;
                    out_seg_next   = '0;
                    out_last_next  = 1'b1;
                    out_win_next   = win_reg;
                    out_thr_next   = lim_reg;
                    out_ss_next    = (lim_reg > win_reg);
                    out_dup_next   = loss_next;
                    state_next     = ST_IDLE;
                end
            end

            ST_UPDATE:
            begin
                if (out_free)
                begin
                    priority if (loss_reg)
                    begin
                        lim_next = win_reg >> 1;
                        win_next = tcw_pkg::RST_WINDOW;
                    end
                    else if (win_dbl < {1'b0, lim_reg})
                        win_next = clamp_win(win_dbl);
                    else if (win_reg < lim_reg)
                        win_next = clamp_win({1'b0, lim_reg});
                    else
                        win_next = clamp_win(win_inc);
                    dup_next       = tcw_pkg::RST_DUP_CNT;
                    loss_next      = 1'b0;
                    out_valid_next = 1'b1;
                    out_kind_next  = tcw_pkg::KIND_UPDATE;
                    out_seg_next   = '0;
                    out_last_next  = 1'b1;
                    out_win_next   = win_next;
                    out_thr_next   = lim_next;
                    out_ss_next    = (lim_next > win_next);
                    out_dup_next   = loss_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acked_reg     <= tcw_pkg::RST_SEQUENCE;
            ack_in_reg    <= '0;
            win_reg       <= tcw_pkg::RST_WINDOW;
            lim_reg       <= tcw_pkg::RST_THRESHOLD;
            dup_reg       <= tcw_pkg::RST_DUP_CNT;
            dup_thr_reg   <= tcw_pkg::RST_DUP_THR;
            loss_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= '0;
            out_seg_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_win_reg   <= '0;
            out_thr_reg   <= '0;
            out_ss_reg    <= 1'b0;
            out_dup_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acked_reg     <= acked_next;
            ack_in_reg    <= ack_in_next;
            win_reg       <= win_next;
            lim_reg       <= lim_next;
            dup_reg       <= dup_next;
            dup_thr_reg   <= dup_thr_next;
            loss_reg      <= loss_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_seg_reg   <= out_seg_next;
            out_last_reg  <= out_last_next;
            out_win_reg   <= out_win_next;
            out_thr_reg   <= out_thr_next;
            out_ss_reg    <= out_ss_next;
            out_dup_reg   <= out_dup_next;
        end
    end

endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
    localparam int                   CFG_SETTLE  = 8;
    localparam int                   END_SETTLE  = 20;
    localparam int unsigned          CYCLE_LIMIT = 400000;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [SEQ_W-1:0] ack;
    } tcw_request_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seg;
        logic              last;
        logic [WIN_W-1:0]  window;
        logic [WIN_W-1:0]  threshold;
        logic              slow_start;
        logic              triple_dup;
    } tcw_result_t;

    logic clk;
    logic rst_n;

    tcw_req_if req_ch();
    tcw_rsp_if rsp_ch();
    tcw_cfg_if cfg_ch();

    tcp_congestion_window_control_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // sender model state
    logic [SEQ_W-1:0] acked_seq;
    logic [WIN_W-1:0] cwnd;
    logic [WIN_W-1:0] ssthresh;
    logic [DUP_W-1:0] dup_count;
    logic             loss_flag;
    logic [DUP_W-1:0] dup_limit;

    tcw_request_t     outgoing_requests[$];
    tcw_result_t      predicted_responses[$];
    logic [SEQ_W-1:0] gen_acked;

    int          sender_idle_pct   = 9;
    int          receiver_idle_pct = 9;
    int          failures          = 0;
    int unsigned cycle_count       = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [WIN_W-1:0] cap_window(input int w);
        return (w > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : WIN_W'(w);
    endfunction

    function automatic void predict_response(input logic [KIND_W-1:0] kind,
                                             input logic [SEQ_W-1:0] seg,
                                             input logic last,
                                             input logic flag);
        tcw_result_t r;
        r.kind       = kind;
        r.seg        = seg;
        r.last       = last;
        r.window     = cwnd;
        r.threshold  = ssthresh;
        r.slow_start = (ssthresh > cwnd);
        r.triple_dup = flag;
        predicted_responses.push_back(r);
    endfunction

    function automatic void advance_window_state(input logic [OP_W-1:0] op,
                                                 input logic [SEQ_W-1:0] ack);
        int   n;
        int   w;
        int   s;
        logic applied;
        w = int'(cwnd);
        s = int'(ssthresh);
        case (op)
            OP_SEND:
            begin
                n = (w > MAX_WINDOW) ? MAX_WINDOW : w;
                for (int i = 0; i < n; i++)
                    predict_response(KIND_SEGMENT, acked_seq + SEQ_W'(i), (i == n - 1),
                                     loss_flag);
            end
            OP_ACK:
            begin
                if (ack > acked_seq)
                begin
                    acked_seq = ack;
                    dup_count = RST_DUP_CNT;
                end
                else if (ack == acked_seq)
                begin
                    if (dup_count < DUP_CNT_MAX)
                        dup_count = dup_count + 1'b1;
                    if (dup_count == dup_limit)
                        loss_flag = 1'b1;
                end
                predict_response(KIND_ACK, '0, 1'b1, loss_flag);
            end
            OP_UPDATE:
            begin
                applied = loss_flag;
                if (applied)
                begin
                    ssthresh = cwnd >> 1;
                    cwnd     = RST_WINDOW;
                end
                else if (w * 2 < s)
                    cwnd = cap_window(w * 2);
                else if (w < s)
                    cwnd = cap_window(s);
                else
                    cwnd = cap_window(w + 1);
                dup_count = RST_DUP_CNT;
                loss_flag = 1'b0;
                predict_response(KIND_UPDATE, '0, 1'b1, applied);
            end
            default: ;  // unknown op: no effect, no response
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [SEQ_W-1:0] want,
                                        input logic [SEQ_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    function automatic void check_response();
        tcw_result_t want;
        if (predicted_responses.size() == 0)
        begin
            $error("response with no pending prediction: kind %0d segment %0h",
                   rsp_ch.kind, rsp_ch.segment_number);
            failures++;
            return;
        end
        want = predicted_responses.pop_front();
        check_field("kind", SEQ_W'(want.kind), SEQ_W'(rsp_ch.kind));
        check_field("segment_number", want.seg, rsp_ch.segment_number);
        check_field("last", SEQ_W'(want.last), SEQ_W'(rsp_ch.last));
        check_field("window", SEQ_W'(want.window), SEQ_W'(rsp_ch.window));
        check_field("threshold", SEQ_W'(want.threshold), SEQ_W'(rsp_ch.threshold));
        check_field("slow_start", SEQ_W'(want.slow_start), SEQ_W'(rsp_ch.slow_start));
        check_field("triple_dup", SEQ_W'(want.triple_dup), SEQ_W'(rsp_ch.triple_dup));
    endfunction

    // request driver: hold the transaction until accepted, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        tcw_request_t nxt;
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.op         <= OP_SEND;
            req_ch.ack_number <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                advance_window_state(req_ch.op, req_ch.ack_number);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (outgoing_requests.size() > 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    nxt = outgoing_requests.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.op         <= nxt.op;
                    req_ch.ack_number <= nxt.ack;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_response();
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic void queue_item(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] ack);
        outgoing_requests.push_back('{op: op, ack: ack});
        if (op == OP_ACK && ack > gen_acked)
            gen_acked = ack;
    endfunction

    // one round: send, a few acks (mostly duplicates or advances), an occasional unknown op, then usually the update
    function automatic void queue_random_round(inout int count);
        int n_acks;
        int pick;
        queue_item(OP_SEND, $urandom());
        count++;
        n_acks = $urandom_range(0, 4);
        repeat (n_acks)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                queue_item(OP_ACK, gen_acked);
            else if (pick < 80)
                queue_item(OP_ACK, gen_acked + SEQ_W'($urandom_range(1, 64)));
            else if (pick < 90)
                queue_item(OP_ACK, gen_acked - SEQ_W'($urandom_range(1, 16)));
            else
                queue_item(OP_ACK, $urandom());
            count++;
        end
        if ($urandom_range(0, 99) < 8)
            queue_item(OP_UNUSED, $urandom());
        // skip the update now and then to stack rounds
        if ($urandom_range(0, 99) < 90)
        begin
            queue_item(OP_UPDATE, $urandom());
            count++;
        end
    endfunction

    task automatic wait_until_idle(input int settle);
        do
            @(negedge clk);
        while (outgoing_requests.size() != 0 || req_ch.valid ||
               predicted_responses.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SEQ_W-1:0] data);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_INIT_THRESHOLD: ssthresh = data[WIN_W-1:0];
            CFG_START_SEQUENCE:
            begin
                acked_seq = data;
                gen_acked = data;
            end
            CFG_DUP_THRESHOLD: dup_limit = data[DUP_W-1:0];
            default: ;  // unknown index: ignored
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [WIN_W-1:0] thr, input logic [DUP_W-1:0] dup_thr,
                                    input logic [SEQ_W-1:0] seq, input int idle_pct,
                                    input bit pause_midway);
        int phase_items;
        phase_items = 0;
        wait_until_idle(CFG_SETTLE);
        write_register(CFG_INIT_THRESHOLD, ($urandom() & ~32'h7F) | SEQ_W'(thr));
        write_register(CFG_START_SEQUENCE, seq);
        write_register(CFG_DUP_THRESHOLD, ($urandom() & ~32'hF) | SEQ_W'(dup_thr));
        sender_idle_pct   = idle_pct;
        receiver_idle_pct = idle_pct;
        while (phase_items < 7)
            queue_random_round(phase_items);
        // hold off the sender until every response is back
        if (pause_midway)
            wait_until_idle(0);
        while (phase_items < 15)
            queue_random_round(phase_items);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_INIT_THRESHOLD;
        cfg_ch.data  <= '0;
        acked_seq    = RST_SEQUENCE;
        cwnd         = RST_WINDOW;
        ssthresh     = RST_THRESHOLD;
        dup_count    = RST_DUP_CNT;
        loss_flag    = 1'b0;
        dup_limit    = RST_DUP_THR;
        gen_acked    = RST_SEQUENCE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: duplicate loss, lower ack, unknown op, wrap of segment numbers
        queue_item(OP_SEND, 32'h0);
        queue_item(OP_ACK, 32'h1);
        queue_item(OP_ACK, 32'h1);
        queue_item(OP_SEND, 32'hFFFF_FFFF);
        queue_item(OP_UPDATE, 32'h0);
        queue_item(OP_UNUSED, 32'h1234_5678);
        queue_item(OP_ACK, 32'h0);
        queue_item(OP_ACK, 32'hFFFF_FFFF);
        queue_item(OP_ACK, 32'hFFFF_FFFF);
        queue_item(OP_UPDATE, 32'h0);
        queue_item(OP_UPDATE, 32'h0);
        queue_item(OP_SEND, 32'h0);

        // oversized threshold: grow to a full window, then lose with the smallest dup limit that can fire
        wait_until_idle(CFG_SETTLE);
        write_register(CFG_INIT_THRESHOLD, 32'd127);
        write_register(CFG_START_SEQUENCE, 32'h0);
        write_register(CFG_DUP_THRESHOLD, 32'd2);
        write_register(CFG_UNUSED, $urandom());
        repeat (7) queue_item(OP_UPDATE, 32'h0);
        queue_item(OP_SEND, 32'h0);
        queue_item(OP_ACK, 32'h5);
        queue_item(OP_ACK, 32'h5);
        queue_item(OP_UPDATE, 32'h0);
        queue_item(OP_SEND, 32'h0);

        // largest dup limit: counter reaches its ceiling
        wait_until_idle(CFG_SETTLE);
        write_register(CFG_INIT_THRESHOLD, 32'd64);
        write_register(CFG_START_SEQUENCE, 32'hFFFF_FFF0);
        write_register(CFG_DUP_THRESHOLD, 32'd15);
        repeat (16) queue_item(OP_ACK, 32'hFFFF_FFF0);
        queue_item(OP_SEND, 32'h0);
        queue_item(OP_UPDATE, 32'h0);

        run_random_phase(7'd0, 4'd1, $urandom(), 9, 1'b0);
        run_random_phase(7'($urandom_range(1, 64)), 4'($urandom_range(2, 5)), $urandom(), 9, 1'b1);
        run_random_phase(7'd64, 4'd0, 32'hFFFF_FF00, 0, 1'b0);
        run_random_phase(7'($urandom_range(0, 64)), 4'd3, $urandom(), 9, 1'b0);

        wait_until_idle(END_SETTLE);
        if (failures == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/tcw_pkg.sv
sv/tcw_if.sv
sv/tcw_addcmp.sv
sv/tcp_congestion_window_control_top.sv
test/tb_top.sv
